### hdl/assert_macros.svh
// Assertion macros used by the top level of the servo pulse generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked property, switched off while reset is asserted.
`define RCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds across reset.
`define RCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCS_ASSERT(lbl, prop, msg)
`define RCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hdl/rcs_pkg.sv
// Constants, codes and types of the servo pulse generator.
package rcs_pkg;

  // Channel and position geometry.
  localparam int NUM_CH     = 2;
  localparam int CH_W       = 2;
  localparam int CH_IDX_W   = 1;
  localparam int POS_W      = 10;
  localparam int MAX_POS    = 999;
  localparam int CENTER_POS = 500;

  // Pulse width arithmetic.
  localparam int GAIN_W         = 13;
  localparam int GAIN_FRAC      = 10;
  localparam int PROD_W         = POS_W + GAIN_W;
  localparam int SUM_W          = PROD_W - GAIN_FRAC + 1;
  localparam int WIDTH_W        = 12;
  localparam int WIDTH_SAT      = 4095;
  localparam int MINW_W         = 11;
  localparam int BASE_MIN_WIDTH = 1000;
  localparam int WIDTH_RANGE    = 1000;
  localparam int WIDTH_RESET    = BASE_MIN_WIDTH + CENTER_POS;
  localparam int GAIN_RESET     = 1 << GAIN_FRAC;

  // Gain division by MAX_POS: span * 2^GAIN_FRAC / MAX_POS is written as
  // span + span * RECIP_PRE / MAX_POS, and the second term uses a reciprocal
  // that is exact for every span up to 2000.
  localparam int SPAN_W      = 11;
  localparam int SPAN_S_W    = 12;
  localparam int RECIP_PRE   = (1 << GAIN_FRAC) - MAX_POS;
  localparam int RECIP_MUL   = 67177;
  localparam int RECIP_K     = RECIP_PRE * RECIP_MUL;
  localparam int RECIP_SHIFT = 26;
  localparam int RQ_W        = 32;

  // Travel limits.
  localparam int LIMIT_W = 10;
  localparam logic signed [LIMIT_W-1:0] LIMIT_HI = 10'sd500;
  localparam logic signed [LIMIT_W-1:0] LIMIT_LO = -10'sd500;

  // Frame period.
  localparam int FREQ_W       = 9;
  localparam logic [FREQ_W-1:0] FREQ_MIN = 9'd20;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 9'd300;
  localparam int FREQ_RESET   = 50;
  localparam int TICK_FREQ    = 1000000;
  localparam int TICK_W       = 20;
  localparam int STEP_W       = $clog2(TICK_W);
  localparam int PERIOD_W     = 16;
  localparam int PERIOD_RESET = TICK_FREQ / FREQ_RESET;

  // Port widths.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_PAD_W  = OUT_DATA_W - 2 - NUM_CH - POS_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_CH  = 2'd1,
    ST_BAD_POS = 2'd2
  } status_e;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_SET  = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_0 = 3'd0,
    REG_UPPER_0 = 3'd1,
    REG_LOWER_1 = 3'd2,
    REG_UPPER_1 = 3'd3,
    REG_EN_0    = 3'd4,
    REG_EN_1    = 3'd5,
    REG_FREQ    = 3'd6
  } reg_idx_e;

  // Status of the period divider as seen by the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/rc_servo_pwm_generator.sv
// Top level of the two-channel hobby-servo pulse generator.
//
// Input transactions arrive on in_*: in_tuser selects a tick (0) or a
// set-position command (1), in_tdata carries the channel and position.
// Every transaction gives one result transaction on out_*: a status code,
// both pulse output levels at the frame counter value seen by the item, and
// the stored position of the addressed channel.
// The pipeline takes one transaction per clock while the receiver does not
// stall and no configuration write is busy; the result passes the input
// register, product register and output register. A set-position command
// changes the pulse width at once, so its own levels already use the new width.
// When the receiver stalls, the whole pipeline holds and in_tready falls in
// the same cycle; nothing is dropped.
// The cfg_* port writes limits, enables and the frame rate. A limit write
// keeps cfg_ready low while gain and width are rebuilt; a frame rate write
// keeps it low until the bit-serial period divider is done. Input
// transactions are held off during that time.
// A synchronous reset centres both channels (1500 ticks), enables them,
// sets 50 Hz (20000 ticks) and clears the frame counter and the pipeline.
`include "assert_macros.svh"

module rc_servo_pwm_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [1:0] channel, [11:2] position, [15:12] zero
  input  logic [rcs_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] func
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [1:0] status, [2] pwm_out_0, [3] pwm_out_1, [13:4] stored_position,
  // [15:14] zero
  output logic [rcs_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rcs_pkg::*;

  typedef enum logic [5:0] {
    CFG_IDLE = 6'b000001,
    CFG_DIV  = 6'b000010,
    CFG_GAIN = 6'b000100,
    CFG_MUL  = 6'b001000,
    CFG_WID  = 6'b010000,
    CFG_FREQ = 6'b100000
  } cfg_state_e;

  // Pulse width = minimum width plus scaled position, saturated.
  function automatic logic [WIDTH_W-1:0] width_calc(input logic [MINW_W-1:0] mn,
                                                    input logic [PROD_W-1:0] p);
    logic [SUM_W-1:0] s;
    s = SUM_W'(mn) + SUM_W'(p[PROD_W-1:GAIN_FRAC]);
    return (s > SUM_W'(WIDTH_SAT)) ? WIDTH_W'(WIDTH_SAT) : s[WIDTH_W-1:0];
  endfunction

  // Channel state.
  logic [POS_W-1:0]           positions_r   [NUM_CH];
  logic [GAIN_W-1:0]          gains_r       [NUM_CH];
  logic [MINW_W-1:0]          min_width_r   [NUM_CH];
  logic [WIDTH_W-1:0]         width_r       [NUM_CH];
  logic signed [LIMIT_W-1:0]  lower_limit_r [NUM_CH];
  logic signed [LIMIT_W-1:0]  upper_limit_r [NUM_CH];
  logic [NUM_CH-1:0]          enable_r;
  logic [PERIOD_W-1:0]        period_r;
  logic [PERIOD_W-1:0]        frame_cnt_r;

  // Configuration sequencer.
  cfg_state_e                 cfg_state_r;
  logic [CH_IDX_W-1:0]        cfg_ch_r;
  logic [SPAN_W-1:0]          cfg_span_r;
  logic [RQ_W-1:0]            cfg_q_r;
  logic [PROD_W-1:0]          cfg_wprod_r;
  logic                       cfg_idle;
  logic                       cfg_acc;
  logic signed [LIMIT_W-1:0]  cfg_lim;
  logic                       cfg_lim_ok;
  logic [FREQ_W-1:0]          cfg_freq;
  logic                       cfg_freq_ok;
  logic signed [SPAN_S_W-1:0] cfg_span_s;
  logic [SPAN_W-1:0]          cfg_span_pos;
  logic signed [MINW_W:0]     cfg_min_s;
  logic                       div_start;
  div_stat_t                  div_stat;
  logic [PERIOD_W-1:0]        div_quot;

  // Pipeline.
  logic                       adv;
  logic                       in_acc;
  logic                       s1_valid_r;
  logic                       s1_func_r;
  logic [CH_W-1:0]            s1_ch_r;
  logic [POS_W-1:0]           s1_pos_r;
  logic [CH_IDX_W-1:0]        s1_chi;
  logic                       s1_ch_ok;
  logic                       s1_pos_ok;
  logic                       s1_set;
  logic                       s1_wr;
  logic                       s1_tick;
  status_e                    s1_status;
  logic [POS_W-1:0]           s1_new_pos;
  logic [POS_W-1:0]           s1_stored;
  logic [PROD_W-1:0]          s1_prod;
  logic [PERIOD_W:0]          cnt_inc;
  logic [PERIOD_W-1:0]        cnt_nxt;
  logic                       tick_adv;
  logic                       s2_valid_r;
  status_e                    s2_status_r;
  logic [POS_W-1:0]           s2_stored_r;
  logic                       s2_wr_r;
  logic [CH_IDX_W-1:0]        s2_chi_r;
  logic [PROD_W-1:0]          s2_prod_r;
  logic [PERIOD_W-1:0]        s2_cnt_r;
  logic [WIDTH_W-1:0]         s2_width_new;
  logic [NUM_CH-1:0]          s2_lvl;
  logic                       out_valid_r;
  status_e                    out_status_r;
  logic [NUM_CH-1:0]          out_lvl_r;
  logic [POS_W-1:0]           out_stored_r;

  // Handshakes: the pipeline moves whenever the output register is free.
  assign adv       = !out_valid_r || out_tready;
  assign cfg_idle  = cfg_state_r == CFG_IDLE;
  assign in_tready = adv && cfg_idle;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = cfg_idle;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // Stage 1: decode, choose the position and form the scaled product.
  always_comb begin
    s1_chi     = s1_ch_r[CH_IDX_W-1:0];
    s1_ch_ok   = s1_ch_r < CH_W'(NUM_CH);
    s1_pos_ok  = s1_pos_r <= POS_W'(MAX_POS);
    s1_set     = s1_func_r == FUNC_SET;
    s1_tick    = s1_func_r == FUNC_TICK;
    s1_wr      = s1_set && s1_ch_ok && s1_pos_ok;
    if (s1_set && !s1_ch_ok) begin
      s1_status = ST_BAD_CH;
    end else if (s1_set && !s1_pos_ok) begin
      s1_status = ST_BAD_POS;
    end else begin
      s1_status = ST_OK;
    end
    s1_new_pos = s1_wr ? s1_pos_r : positions_r[s1_chi];
    s1_stored  = s1_ch_ok ? s1_new_pos : '0;
    s1_prod    = PROD_W'(s1_new_pos) * PROD_W'(gains_r[s1_chi]);
    cnt_inc    = {1'b0, frame_cnt_r} + 1'b1;
    cnt_nxt    = (cnt_inc >= {1'b0, period_r}) ? '0 : cnt_inc[PERIOD_W-1:0];
  end

  assign tick_adv = adv && s1_valid_r && s1_tick;

  // Stage 2: finish the new width and compare both channels with the counter.
  always_comb begin
    s2_width_new = width_calc(min_width_r[s2_chi_r], s2_prod_r);
    for (int k = 0; k < NUM_CH; k++) begin
      if (s2_wr_r && s2_chi_r == CH_IDX_W'(k)) begin
        s2_lvl[k] = enable_r[k] && (s2_cnt_r < PERIOD_W'(s2_width_new));
      end else begin
        s2_lvl[k] = enable_r[k] && (s2_cnt_r < PERIOD_W'(width_r[k]));
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_acc;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_tuser;
      s1_ch_r   <= in_tdata[CH_W-1:0];
      s1_pos_r  <= in_tdata[CH_W +: POS_W];
    end
    if (adv) begin
      s2_status_r  <= s1_status;
      s2_stored_r  <= s1_stored;
      s2_wr_r      <= s1_wr;
      s2_chi_r     <= s1_chi;
      s2_prod_r    <= s1_prod;
      s2_cnt_r     <= frame_cnt_r;
      out_status_r <= s2_status_r;
      out_lvl_r    <= s2_lvl;
      out_stored_r <= s2_stored_r;
    end
  end

  // Configuration write decode.
  always_comb begin
    cfg_lim      = signed'(cfg_data);
    cfg_lim_ok   = (cfg_lim >= LIMIT_LO) && (cfg_lim <= LIMIT_HI);
    cfg_freq     = cfg_data[FREQ_W-1:0];
    cfg_freq_ok  = (cfg_freq >= FREQ_MIN) && (cfg_freq <= FREQ_MAX);
    div_start    = cfg_acc && (cfg_index == REG_FREQ) && cfg_freq_ok;
    cfg_span_s   = SPAN_S_W'(WIDTH_RANGE) + SPAN_S_W'(upper_limit_r[cfg_ch_r])
                 - SPAN_S_W'(lower_limit_r[cfg_ch_r]);
    cfg_span_pos = (cfg_span_s > 0) ? cfg_span_s[SPAN_W-1:0] : '0;
    cfg_min_s    = (MINW_W+1)'(BASE_MIN_WIDTH) + (MINW_W+1)'(lower_limit_r[cfg_ch_r]);
  end

  rcs_period_div u_period_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (cfg_freq),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // Configuration sequencer working registers.
  always_ff @(posedge clk) begin
    if (cfg_state_r == CFG_DIV) begin
      cfg_span_r <= cfg_span_pos;
      cfg_q_r    <= RQ_W'(cfg_span_pos) * RQ_W'(RECIP_K);
    end
    if (cfg_state_r == CFG_MUL) begin
      cfg_wprod_r <= PROD_W'(positions_r[cfg_ch_r]) * PROD_W'(gains_r[cfg_ch_r]);
    end
  end

  // Channel state, frame counter and configuration sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        positions_r[c]   <= POS_W'(CENTER_POS);
        gains_r[c]       <= GAIN_W'(GAIN_RESET);
        min_width_r[c]   <= MINW_W'(BASE_MIN_WIDTH);
        width_r[c]       <= WIDTH_W'(WIDTH_RESET);
        lower_limit_r[c] <= '0;
        upper_limit_r[c] <= '0;
      end
      enable_r    <= '1;
      period_r    <= PERIOD_W'(PERIOD_RESET);
      frame_cnt_r <= '0;
      cfg_state_r <= CFG_IDLE;
      cfg_ch_r    <= '0;
    end else begin
      // Item side: stored positions, counter advance and new widths.
      if (adv && s1_valid_r && s1_wr) begin
        positions_r[s1_chi] <= s1_pos_r;
      end
      if (tick_adv) begin
        frame_cnt_r <= cnt_nxt;
      end
      if (adv && s2_valid_r && s2_wr_r) begin
        width_r[s2_chi_r] <= s2_width_new;
      end

      // Configuration side.
      unique case (cfg_state_r)
        CFG_IDLE: begin
          if (cfg_acc) begin
            unique case (cfg_index) inside
              REG_LOWER_0, REG_UPPER_0, REG_LOWER_1, REG_UPPER_1: begin
                // Bit 1 of the index picks the channel, bit 0 picks the
                // upper or lower limit.
                if (cfg_lim_ok) begin
                  if (cfg_index[0]) begin
                    upper_limit_r[cfg_index[1]] <= cfg_lim;
                  end else begin
                    lower_limit_r[cfg_index[1]] <= cfg_lim;
                  end
                  cfg_ch_r    <= cfg_index[1];
                  cfg_state_r <= CFG_DIV;
                end
              end
              REG_EN_0, REG_EN_1: begin
                enable_r[cfg_index[0]] <= cfg_data[0];
              end
              REG_FREQ: begin
                if (cfg_freq_ok) begin
                  cfg_state_r <= CFG_FREQ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        CFG_DIV: begin
          cfg_state_r <= CFG_GAIN;
        end
        CFG_GAIN: begin
          // Largest gain is 2050, so it never reaches the 13-bit ceiling.
          gains_r[cfg_ch_r] <= GAIN_W'(cfg_span_r) + GAIN_W'(cfg_q_r >> RECIP_SHIFT);
          cfg_state_r       <= CFG_MUL;
        end
        CFG_MUL: begin
          min_width_r[cfg_ch_r] <= cfg_min_s[MINW_W-1:0];
          cfg_state_r           <= CFG_WID;
        end
        CFG_WID: begin
          width_r[cfg_ch_r] <= width_calc(min_width_r[cfg_ch_r], cfg_wprod_r);
          cfg_state_r       <= CFG_IDLE;
        end
        CFG_FREQ: begin
          if (div_stat.done) begin
            period_r    <= div_quot;
            cfg_state_r <= CFG_IDLE;
          end
        end
        default: begin
          cfg_state_r <= CFG_IDLE;
        end
      endcase
    end
  end

  // Result channel.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_PAD_W'(0), out_stored_r, out_lvl_r, out_status_r};

  // Checks on the pipeline and the configuration sequencer.
  `RCS_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_tvalid, "reset left a result pending")
  `RCS_ASSERT(a_cnt_in_period, tick_adv && cfg_idle |=> frame_cnt_r < period_r || frame_cnt_r == '0, "frame counter ran past the period")
  `RCS_ASSERT(a_pipe_to_out, s2_valid_r && adv |=> out_valid_r, "result lost between stage two and output")
  `RCS_ASSERT(a_no_cfg_while_div, div_stat.busy |-> !cfg_ready, "configuration taken while period divider busy")

endmodule

### hdl/rcs_period_div.sv
// Bit-serial divider that turns the frame rate into a period in frame counter ticks.
module rcs_period_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rcs_pkg::FREQ_W-1:0]   divisor,
  output rcs_pkg::div_stat_t           stat,
  output logic [rcs_pkg::PERIOD_W-1:0] quotient
);
  import rcs_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [TICK_W-1:0] dvd_r;
  logic [FREQ_W-1:0] rem_r;
  logic [FREQ_W-1:0] dsr_r;
  logic [FREQ_W:0]   trial;
  logic [FREQ_W:0]   diff;
  logic              ge;
  logic [FREQ_W-1:0] rem_nxt;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial   = {rem_r, dvd_r[TICK_W-1]};
    diff    = trial - {1'b0, dsr_r};
    ge      = trial >= {1'b0, dsr_r};
    rem_nxt = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
  end

  // Control: one step per cycle, a done pulse after the last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(TICK_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient bits shift in where the dividend bits leave.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= TICK_W'(TICK_FREQ);
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[TICK_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r[PERIOD_W-1:0];

endmodule

### tb/tb_top.sv
// Self-checking testbench for the two-channel servo pulse generator.
`timescale 1ns / 1ps

module tb_top;
  import rcs_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 11;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE_TICKS = 24;
  localparam int GAIN_CEIL    = (1 << GAIN_W) - 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    func_e             func;
    logic [CH_W-1:0]   chan;
    logic [POS_W-1:0]  pos;
  } servo_cmd_t;

  typedef struct packed {
    status_e           status;
    logic              lvl0;
    logic              lvl1;
    logic [POS_W-1:0]  stored;
  } pwm_report_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rc_servo_pwm_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Mirror of the block's state.
  int servo_pos[NUM_CH];
  int servo_gain[NUM_CH];
  int servo_minw[NUM_CH];
  int servo_width[NUM_CH];
  int lim_lower[NUM_CH];
  int lim_upper[NUM_CH];
  bit chan_en[NUM_CH];
  int frame_len;
  int frame_cnt;

  servo_cmd_t  pending_cmds[$];
  pwm_report_t pwm_reports_due[$];
  servo_cmd_t  cmd_on_bus;
  pwm_report_t report_want;

  int  fail_count = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  hold_request = 1'b0;
  bit  steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Pulse width from stored position, gain and minimum width.
  function automatic void rebuild_width(int ch);
    int w;
    w = servo_minw[ch] + ((servo_pos[ch] * servo_gain[ch]) >>> GAIN_FRAC);
    servo_width[ch] = (w > WIDTH_SAT) ? WIDTH_SAT : w;
  endfunction

  // Gain and minimum width follow the two travel limits of a channel.
  function automatic void rebuild_gain(int ch);
    int span;
    int g;
    span = WIDTH_RANGE + lim_upper[ch] - lim_lower[ch];
    g = (span > 0) ? (span << GAIN_FRAC) / MAX_POS : 0;
    servo_gain[ch] = (g > GAIN_CEIL) ? GAIN_CEIL : g;
    servo_minw[ch] = BASE_MIN_WIDTH + lim_lower[ch];
    rebuild_width(ch);
  endfunction

  function automatic void reset_servo_state();
    for (int ch = 0; ch < NUM_CH; ch++) begin
      lim_lower[ch] = 0;
      lim_upper[ch] = 0;
      servo_pos[ch] = CENTER_POS;
      chan_en[ch]   = 1'b1;
      rebuild_gain(ch);
    end
    frame_len = TICK_FREQ / FREQ_RESET;
    frame_cnt = 0;
  endfunction

  // Register write as the block applies it; out-of-range values are dropped.
  function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    int lim;
    int ch;
    int hz;
    lim = int'($signed(val));
    ch  = int'(idx) >> 1;
    hz  = int'(val[FREQ_W-1:0]);
    case (idx)
      REG_LOWER_0, REG_UPPER_0, REG_LOWER_1, REG_UPPER_1: begin
        if (lim <= int'(LIMIT_HI) && lim >= int'(LIMIT_LO)) begin
          if (idx[0]) lim_upper[ch] = lim;
          else lim_lower[ch] = lim;
          rebuild_gain(ch);
        end
      end
      REG_EN_0: chan_en[0] = val[0];
      REG_EN_1: chan_en[1] = val[0];
      REG_FREQ: begin
        if (hz >= int'(FREQ_MIN) && hz <= int'(FREQ_MAX)) frame_len = TICK_FREQ / hz;
      end
      default: ;
    endcase
  endfunction

  // One command: position update, output levels, then the counter advance.
  function automatic pwm_report_t servo_step(servo_cmd_t cmd);
    pwm_report_t r;
    int nxt;
    r.status = ST_OK;
    if (cmd.func == FUNC_SET) begin
      if (cmd.chan >= NUM_CH) begin
        r.status = ST_BAD_CH;
      end else if (cmd.pos > MAX_POS) begin
        r.status = ST_BAD_POS;
      end else begin
        servo_pos[cmd.chan] = cmd.pos;
        rebuild_width(cmd.chan);
      end
    end
    r.stored = (cmd.chan < NUM_CH) ? POS_W'(servo_pos[cmd.chan]) : '0;
    r.lvl0 = chan_en[0] && (frame_cnt < servo_width[0]);
    r.lvl1 = chan_en[1] && (frame_cnt < servo_width[1]);
    if (cmd.func == FUNC_TICK) begin
      nxt = frame_cnt + 1;
      frame_cnt = (nxt >= frame_len) ? 0 : nxt;
    end
    return r;
  endfunction

  function automatic servo_cmd_t make_cmd(func_e f, int ch, int p);
    servo_cmd_t c;
    c.func = f;
    c.chan = CH_W'(ch);
    c.pos  = POS_W'(p);
    return c;
  endfunction

  // Mostly ticks and valid positions on built channels, with some errors.
  function automatic servo_cmd_t rand_cmd();
    func_e f;
    int ch;
    int p;
    f  = ($urandom_range(0, 99) < 65) ? FUNC_TICK : FUNC_SET;
    ch = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 1) : $urandom_range(2, 3);
    p  = ($urandom_range(0, 99) < 90) ? $urandom_range(0, MAX_POS)
                                      : $urandom_range(MAX_POS + 1, (1 << POS_W) - 1);
    return make_cmd(f, ch, p);
  endfunction

  // Sampled at the falling edge so that no posedge update is missed.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_tvalid || pwm_reports_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    logic [CFG_DATA_W-1:0] bits;
    bits = val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= bits;
    do @(posedge clk);
    while (!cfg_ready);
    apply_setting(idx, bits);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_ticks(input int count);
    for (int i = 0; i < count; i++)
      pending_cmds.push_back(make_cmd(FUNC_TICK, $urandom_range(0, 3),
                                      $urandom_range(0, (1 << POS_W) - 1)));
  endtask

  // Random settings between random phases, now and then out of range.
  task automatic shuffle_settings();
    int lim;
    for (int r = int'(REG_LOWER_0); r <= int'(REG_UPPER_1); r++) begin
      if ($urandom_range(0, 1) == 1) begin
        lim = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 1023))
                                            : int'($urandom_range(0, 1000)) - 500;
        write_reg(CFG_IDX_W'(r), lim);
      end
    end
    if ($urandom_range(0, 3) == 0) write_reg(REG_EN_0, $urandom_range(0, 1023));
    if ($urandom_range(0, 3) == 0) write_reg(REG_EN_1, $urandom_range(0, 1023));
    if ($urandom_range(0, 1) == 1)
      write_reg(REG_FREQ, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                      : $urandom_range(20, 300));
    // Bring both outputs back on in about half of the calls.
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_EN_0, 1);
      write_reg(REG_EN_1, 1);
    end
  endtask

  // Command driver: offers queued commands, predicts each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) pwm_reports_due.push_back(servo_step(cmd_on_bus));
      if (pending_cmds.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        cmd_on_bus = pending_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= cmd_on_bus.func;
        in_tdata  <= {{(IN_DATA_W - POS_W - CH_W){1'b0}}, cmd_on_bus.pos, cmd_on_bus.chan};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold on request.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Result monitor: each transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pwm_reports_due.size() == 0) begin
        $error("result with nothing predicted: tdata %h", out_tdata);
        fail_count++;
      end else begin
        report_want = pwm_reports_due.pop_front();
        if (out_tdata[1:0] !== report_want.status) begin
          $error("status: expected %0d, got %0d", report_want.status, out_tdata[1:0]);
          fail_count++;
        end
        if (out_tdata[2] !== report_want.lvl0) begin
          $error("pwm_out_0: expected %0d, got %0d", report_want.lvl0, out_tdata[2]);
          fail_count++;
        end
        if (out_tdata[3] !== report_want.lvl1) begin
          $error("pwm_out_1: expected %0d, got %0d", report_want.lvl1, out_tdata[3]);
          fail_count++;
        end
        if (out_tdata[13:4] !== report_want.stored) begin
          $error("stored_position: expected %0d, got %0d", report_want.stored,
                 out_tdata[13:4]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    reset_servo_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Field extremes and the error codes at reset settings.
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_SET, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_SET, 1, MAX_POS));
    pending_cmds.push_back(make_cmd(FUNC_SET, 0, MAX_POS + 1));
    pending_cmds.push_back(make_cmd(FUNC_SET, 1, 1023));
    pending_cmds.push_back(make_cmd(FUNC_SET, 2, 0));
    pending_cmds.push_back(make_cmd(FUNC_SET, 3, 1023));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 3, 1023));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 1, 512));
    pending_cmds.push_back(make_cmd(FUNC_SET, 0, MAX_POS));
    pending_cmds.push_back(make_cmd(FUNC_SET, 1, 0));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 2, 341));
    wait_idle();

    // Limit extremes; the second channel gets a span of zero, so no gain.
    write_reg(REG_LOWER_0, -500);
    write_reg(REG_UPPER_0, 500);
    write_reg(REG_LOWER_1, 500);
    write_reg(REG_UPPER_1, -500);
    pending_cmds.push_back(make_cmd(FUNC_SET, 0, MAX_POS));
    pending_cmds.push_back(make_cmd(FUNC_SET, 1, MAX_POS));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 682));
    wait_idle();

    // Out-of-range limit writes must leave the registers alone.
    write_reg(REG_LOWER_0, 501);
    write_reg(REG_UPPER_0, -501);
    write_reg(REG_LOWER_1, 511);
    write_reg(REG_UPPER_1, -512);
    pending_cmds.push_back(make_cmd(FUNC_SET, 1, 1));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 1, 0));
    wait_idle();

    // Outputs disabled; only bit 0 of the enable value counts.
    write_reg(REG_EN_0, 0);
    write_reg(REG_EN_1, 10'h3FE);
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_SET, 0, 250));
    wait_idle();
    write_reg(REG_EN_0, 1);
    write_reg(REG_EN_1, 10'h001);

    // Frame rate: rejected values, both extremes and an unused index.
    write_reg(REG_FREQ, 19);
    write_reg(REG_FREQ, 301);
    write_reg(REG_FREQ, 0);
    write_reg(REG_FREQ, 511);
    write_reg(REG_FREQ, 300);
    write_reg(REG_SPARE, 10'h155);
    pending_cmds.push_back(make_cmd(FUNC_TICK, 1, 999));
    wait_idle();
    write_reg(REG_FREQ, 20);

    // Long tick run: narrow pulses end, then the counter passes 3333.
    write_reg(REG_LOWER_0, -500);
    write_reg(REG_UPPER_0, 0);
    write_reg(REG_LOWER_1, -500);
    write_reg(REG_UPPER_1, 0);
    pending_cmds.push_back(make_cmd(FUNC_SET, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_SET, 1, 10));
    push_ticks(3500);
    wait_idle();

    // A shorter frame than the current count wraps on the next tick.
    write_reg(REG_FREQ, 300);
    push_ticks(3400);
    wait_idle();

    // Random phases, each started from an idle block with fresh settings.
    for (int phase = 0; phase < 7; phase++) begin
      shuffle_settings();
      steady = (phase == 2);
      if (phase == 4) hold_request = 1'b1;
      for (int i = 0; i < 100; i++) pending_cmds.push_back(rand_cmd());
      wait_idle();
      steady = 1'b0;
    end

    wait_idle();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
